@@ rtl/bsxh_pkg.sv @@
// ----------------------------------------------------------------------------
// bsxh_pkg: shared constants and helpers for the byte stream shift/xor hash
// Mixing constants, masks and the byte bit-reversal used by the hash stages.
// ----------------------------------------------------------------------------
package bsxh_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HASH_W = 64;
  localparam int unsigned HALF_W = 32;

  localparam logic [HASH_W-1:0] MASK_LOW32  = 64'h0000_0000_ffff_ffff;
  localparam logic [HALF_W-1:0] XOR_NARROW  = 32'h0000_00ff;
  localparam logic [HASH_W-1:0] XOR_WIDE    = 64'h0000_0000_0000_ffff;
  localparam logic [HASH_W-1:0] WIDE_LIMIT  = 64'h0000_0000_ff00_0000;
  localparam logic [HASH_W-1:0] WIDE_ADDEND = 64'h00ff_ffff_ffff_ffff;
  localparam logic [HASH_W-1:0] WIDE_TOPINV = 64'hff00_0000_0000_0000;

  typedef logic [HASH_W-1:0] hash_word_t;

  // Mirror the bit order of one byte.
  function automatic logic [BYTE_W-1:0] bit_reverse8(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    for (int k = 0; k < BYTE_W; k++) begin
      r[k] = b[BYTE_W-1-k];
    end
    return r;
  endfunction

endpackage

@@ rtl/bsxh_absorb.sv @@
// ----------------------------------------------------------------------------
// bsxh_absorb: per-byte accumulator update
// Loads the reversed first byte on message start, then mixes in the byte.
// ----------------------------------------------------------------------------
module bsxh_absorb (
  input  bsxh_pkg::hash_word_t acc_in,
  input  logic [7:0]           data_byte,
  input  logic                 start,
  input  logic                 wide,
  output bsxh_pkg::hash_word_t acc_out,
  output logic [7:0]           rev_out
);
  import bsxh_pkg::*;

  hash_word_t        acc_base;
  hash_word_t        w_sum;
  hash_word_t        w_mix;
  hash_word_t        w_res;
  logic [HALF_W-1:0] n_acc;
  logic [HALF_W-1:0] n_sum;
  logic [HALF_W-1:0] n_mix;

  assign rev_out  = bit_reverse8(data_byte);
  assign acc_base = start ? {56'd0, rev_out} : acc_in;

  // 64-bit variant
  always_comb begin
    w_sum = acc_base + ({49'd0, data_byte, 7'd0} | (acc_base >> 31));
    w_mix = (w_sum ^ (w_sum >> 6)) ^ XOR_WIDE;
    if (w_mix <= WIDE_LIMIT) begin
      w_res = (w_mix + WIDE_ADDEND) ^ WIDE_TOPINV;
    end else begin
      w_res = w_mix;
    end
  end

  // 32-bit variant, modulo 2^32
  assign n_acc = acc_base[HALF_W-1:0];
  assign n_sum = n_acc + ({17'd0, data_byte, 7'd0} | (n_acc >> 15));
  assign n_mix = (n_sum ^ (n_sum >> 6)) ^ XOR_NARROW;

  assign acc_out = wide ? w_res : {32'd0, n_mix};

endmodule

@@ rtl/bsxh_finish.sv @@
// ----------------------------------------------------------------------------
// bsxh_finish: end-of-message finalization
// Shift/add/xor avalanche, then add the reversed first byte.
// ----------------------------------------------------------------------------
module bsxh_finish (
  input  bsxh_pkg::hash_word_t acc_in,
  input  logic [7:0]           first_rev,
  input  logic                 wide,
  output bsxh_pkg::hash_word_t hash_out
);
  import bsxh_pkg::*;

  hash_word_t mask;
  hash_word_t a0;
  hash_word_t a1;
  hash_word_t a2;
  hash_word_t a3;

  assign mask     = wide ? {HASH_W{1'b1}} : MASK_LOW32;
  assign a0       = acc_in & mask;
  assign a1       = (a0 + (a0 << 3)) & mask;
  assign a2       = a1 ^ (a1 >> 11);
  assign a3       = (a2 + (a2 << 15)) & mask;
  assign hash_out = (a3 + {56'd0, first_rev}) & mask;

endmodule

@@ rtl/byte_stream_shift_xor_hash_unit.sv @@
// ----------------------------------------------------------------------------
// byte_stream_shift_xor_hash_unit: streaming byte hash, 32-bit or 64-bit
// Hashes a message delivered one byte per transfer and emits one hash word
// per message on the output stream.
// ----------------------------------------------------------------------------
// The unit takes one message byte per clock on the input stream, with tlast
// marking the final byte, and emits exactly one 64-bit hash per message
// (upper 32 bits zero in 32-bit mode). Throughput is one byte per cycle,
// sustained, also across message boundaries, while the output keeps up. A
// byte is held in the input register, mixed into the accumulator by the
// absorb logic as it leaves that register, and, if it is the last byte,
// finalized from the finish stage into the output register. The
// accumulator feedback through the absorb logic is the one loop that sets
// the one-byte-per-cycle figure. Stalls on the output stream only hold back
// last bytes; data bytes keep flowing while a finished hash waits. Write
// wide_mode only while no message is in flight.
module byte_stream_shift_xor_hash_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration: bit 0 = wide_mode
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [63:0] hash_value
);
  import bsxh_pkg::*;

  // configuration
  logic       wide_mode;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // message state
  hash_word_t accumulator;
  logic [7:0] first_reversed;
  logic       in_message;

  // finalization stage
  logic       fin_valid;
  hash_word_t fin_acc;
  logic [7:0] fin_rev;
  logic       fin_wide;

  // output register
  logic       out_valid;
  hash_word_t out_hash;

  // combinational results
  hash_word_t accumulator_next;
  logic [7:0] rev_next;
  hash_word_t hash_next;

  // handshake control
  logic out_free;
  logic fin_free;
  logic in_move;

  assign out_free      = !out_valid || m_axis_tready;
  assign fin_free      = !fin_valid || out_free;
  // a data byte always moves on; a last byte waits for room in the finish stage
  assign in_move       = in_valid && (!in_last || fin_free);
  assign s_axis_tready = !in_valid || in_move;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_hash;

  bsxh_absorb u_absorb (
    .acc_in    (accumulator),
    .data_byte (in_byte),
    .start     (!in_message),
    .wide      (wide_mode),
    .acc_out   (accumulator_next),
    .rev_out   (rev_next)
  );

  bsxh_finish u_finish (
    .acc_in    (fin_acc),
    .first_rev (fin_rev),
    .wide      (fin_wide),
    .hash_out  (hash_next)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      wide_mode <= cfg_wr_data;
    end
  end

  // input register: load on transfer, drop once the byte is absorbed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // absorb: advance the accumulator, capture the first byte on message start
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= '0;
      first_reversed <= '0;
      in_message     <= 1'b0;
    end else if (in_move) begin
      accumulator <= accumulator_next;
      if (!in_message) begin
        first_reversed <= rev_next;
      end
      in_message <= !in_last;
    end
  end

  // finish stage: take the final accumulator and the first byte of this message
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (in_move && in_last) begin
      fin_valid <= 1'b1;
    end else if (out_free) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move && in_last) begin
      fin_acc  <= accumulator_next;
      fin_rev  <= in_message ? first_reversed : rev_next;
      fin_wide <= wide_mode;
    end
  end

  // output register: hold the hash until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fin_valid) begin
      out_hash <= hash_next;
    end
  end

endmodule

@@ dv/byte_stream_shift_xor_hash_unit_tb.sv @@
// ----------------------------------------------------------------------------
// byte_stream_shift_xor_hash_unit_tb: self-checking bench for the byte hash
// Streams messages in 32-bit and 64-bit mode under random input gaps and
// output stalls, predicts each hash in the bench and checks every transfer.
// ----------------------------------------------------------------------------
module byte_stream_shift_xor_hash_unit_tb;
  import bsxh_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  // Extra settle time after the last expected hash has arrived.
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 320;
  localparam int LONG_HOLD      = 80;

  localparam logic MODE_NARROW = 1'b0;
  localparam logic MODE_WIDE   = 1'b1;

  // Receiver stall patterns.
  localparam int RX_ALWAYS = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_SPARSE = 2;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_wr_en     = 1'b0;
  logic        cfg_wr_data   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0;    // last_byte
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [63:0] m_axis_tdata;            // [63:0] hash_value

  // Bench copy of the hash state and the mode register.
  hash_word_t acc_state       = '0;
  logic [7:0] first_rev_state = 8'h00;
  logic       in_msg_state    = 1'b0;
  logic       wide_state      = 1'b0;

  hash_word_t pending_hashes[$];
  hash_word_t expected_hash;
  int         errors = 0;

  // Sender burst shaping.
  int burst_left = 0;
  int gap_len    = 0;

  // Long hold-off requests for the receiver: the test bumps hold_requests,
  // the receiver serves each one by counting hold_len_req cycles itself.
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_len_req  = 0;
  int hold_left     = 0;
  int stall_mode    = RX_ALWAYS;
  int stretch_left  = 0;

  int idle_cycles = 0;

  byte_stream_shift_xor_hash_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Hash predictor: absorb one accepted byte into the bench state and, on a
  // last byte, finalize and queue the expected hash.
  // --------------------------------------------------------------------------
  task automatic advance_hash(input logic [7:0] d, input logic l);
    hash_word_t a;
    hash_word_t m;
    logic [7:0] r;
    // First byte of a message: seed with its bit-mirrored value.
    if (!in_msg_state) begin
      for (int k = 0; k < 8; k++) r[k] = d[7-k];
      first_rev_state = r;
      acc_state       = {56'd0, r};
      in_msg_state    = 1'b1;
    end
    a = acc_state;
    if (wide_state) begin
      a = a + (({56'd0, d} << 7) | (a >> 31));
      a = a ^ (a >> 6);
      a = a ^ XOR_WIDE;
      // Small accumulators get pushed up and their top byte flipped.
      if (a <= WIDE_LIMIT) begin
        a = a + WIDE_ADDEND;
        a = a ^ WIDE_TOPINV;
      end
    end else begin
      a = a & MASK_LOW32;
      a = (a + (({56'd0, d} << 7) | (a >> 15))) & MASK_LOW32;
      a = a ^ (a >> 6);
      a = a ^ {32'd0, XOR_NARROW};
    end
    acc_state = a;
    if (l) begin
      m = wide_state ? {HASH_W{1'b1}} : MASK_LOW32;
      a = a & m;
      a = (a + (a << 3)) & m;
      a = a ^ (a >> 11);
      a = (a + (a << 15)) & m;
      a = (a + {56'd0, first_rev_state}) & m;
      pending_hashes.push_back(a);
      in_msg_state = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Offer one byte and hold it until the transfer happens. On return tvalid
  // may still be high, so any caller that does not send next must lower it.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] d, input logic l);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    advance_hash(d, l);
    if (burst_left > 0) burst_left--;
    // End of a burst: pick the next one and maybe idle for a random gap.
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap_len > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom_range(0, 255));
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  task automatic send_random_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Drop tvalid and wait until every expected hash has arrived, then let the
  // pipeline settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mode changes happen only with the block idle.
  task automatic write_mode(input logic v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    wide_state  = v;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // 32-bit mode: one-byte messages at the byte extremes, then short messages.
  task automatic test_directed_narrow();
    write_mode(MODE_NARROW);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h5a, 1'b1);
  endtask

  // 64-bit mode: the first byte always lands below the wide limit, so the
  // top-byte fold is hit on every message here.
  task automatic test_directed_wide();
    write_mode(MODE_WIDE);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h3c, 1'b1);
  endtask

  // Hold the output off for a long stretch while short messages keep coming,
  // so finished hashes back up and the input stalls on a last byte.
  task automatic test_output_backpressure();
    int sent;
    sent = 0;
    hold_len_req = LONG_HOLD;
    hold_requests++;
    while (sent < 40) begin
      gap_len = $urandom_range(1, 3);
      send_random_message(gap_len);
      sent += gap_len;
    end
    drain_results();
  endtask

  // Random messages in phases; each phase picks a mode and drains at the end.
  task automatic test_random_messages();
    int total;
    int phase_target;
    int phase_sent;
    int len;
    total = 0;
    while (total < RANDOM_BYTES) begin
      write_mode(1'($urandom_range(0, 1)));
      phase_target = $urandom_range(30, 90);
      phase_sent   = 0;
      while (phase_sent < phase_target) begin
        len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
        send_random_message(len);
        phase_sent += len;
      end
      total += phase_sent;
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: long holds on request, otherwise stretches of a stall pattern.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = hold_len_req;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stall_mode   = $urandom_range(RX_ALWAYS, RX_SPARSE);
          stretch_left = $urandom_range(8, 40);
        end
        stretch_left--;
        case (stall_mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= ($urandom_range(0, 9) >= 3);
          default:   m_axis_tready <= ((stretch_left % 4) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each output transfer with the oldest expected hash.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t ERROR: hash_value expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        expected_hash = pending_hashes.pop_front();
        if (m_axis_tdata !== expected_hash) begin
          $display("%0t ERROR: hash_value expected %h, actual %h",
                   $time, expected_hash, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_narrow();
    test_directed_wide();
    test_output_backpressure();
    test_random_messages();
    drain_results();
    if (errors == 0 && pending_hashes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
